>>> hw/rtl/cam_pkg.sv
// Shared types and constants for the addressing mode unit.
`timescale 1ns / 1ps

package cam_pkg;

   localparam int QueueDepthDefault = 4;

   typedef enum logic [3:0] {
      MODE_ACC  = 4'd0,
      MODE_ABS  = 4'd1,
      MODE_ABSX = 4'd2,
      MODE_ABSY = 4'd3,
      MODE_IMM  = 4'd4,
      MODE_IMP  = 4'd5,
      MODE_IND  = 4'd6,
      MODE_INDX = 4'd7,
      MODE_INDY = 4'd8,
      MODE_REL  = 4'd9,
      MODE_ZPG  = 4'd10,
      MODE_ZPGX = 4'd11,
      MODE_ZPGY = 4'd12
   } mode_type;

   typedef enum logic {
      OP_BEGIN = 1'b0,
      OP_DATA  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_FIRST  = 2'd1,
      PH_SECOND = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CMD_DIRECT = 2'd0,
      CMD_READ   = 2'd1,
      CMD_WORD   = 2'd2
   } cmd_kind_type;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // One classified word handed from the front to the back.
   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   mode;
      logic [7:0]   lo;
      logic [7:0]   hi;
      logic [7:0]   x;
      logic [7:0]   y;
      logic [15:0]  pc;
      logic [15:0]  addr;
   } cmd_type;

endpackage

>>> hw/rtl/cpu_addressing_mode_unit.sv
// Top level of the addressing mode unit.
//
// Input side is a queue write port: a word (begin or returned bus byte) is
// taken at a clock edge with req_push high and req_full low. Result side is
// a queue read port: the oldest result sits on the rsp_ ports while rsp_empty
// is low and leaves at an edge with rsp_pop high.
// A begin word for a direct mode gives one done result. An indirect mode
// gives a read request; each returned byte pushed back gives the next read
// request and then the done result. A data word while idle gives nothing.
// The front classifies one word per cycle while req_full is low and writes
// a command queue of QUEUE_DEPTH entries; the back drains one command per
// cycle, while the result register is free or being popped, into that
// register. Throughput is one word per cycle while req_full is low; an
// accepted word is registered in the queue, then in the result register.
// When the consumer stops popping, the result register holds, the queue
// fills, and req_full rises after QUEUE_DEPTH more results are queued.
// Synchronous reset empties the queue and the result register and returns
// the indirect sequencer to idle.
`timescale 1ns / 1ps

module cpu_addressing_mode_unit import cam_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_operation,
   input  logic [3:0]  req_mode,
   input  logic [7:0]  req_operand_low,
   input  logic [7:0]  req_operand_high,
   input  logic [7:0]  req_index_x,
   input  logic [7:0]  req_index_y,
   input  logic [15:0] req_operand_pc,
   input  logic [7:0]  req_read_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_kind,
   output logic [15:0] rsp_address,
   output logic        rsp_use_accumulator,
   output logic        rsp_page_crossed
);

   logic    accept;
   logic    cmd_valid;
   cmd_type cmd_wr;
   cmd_type cmd_rd;
   logic    q_not_empty;
   logic    cmd_take;

   assign accept = req_push && !req_full;

   cam_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_operation),
      .mode         (req_mode),
      .operand_low  (req_operand_low),
      .operand_high (req_operand_high),
      .index_x      (req_index_x),
      .index_y      (req_index_y),
      .operand_pc   (req_operand_pc),
      .read_data    (req_read_data),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd_wr)
   );

   cam_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (cmd_valid),
      .wr_data   (cmd_wr),
      .full      (req_full),
      .rd_en     (cmd_take),
      .not_empty (q_not_empty),
      .rd_data   (cmd_rd)
   );

   cam_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_present         (q_not_empty),
      .cmd                 (cmd_rd),
      .cmd_take            (cmd_take),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_kind            (rsp_kind),
      .rsp_address         (rsp_address),
      .rsp_use_accumulator (rsp_use_accumulator),
      .rsp_page_crossed    (rsp_page_crossed)
   );

endmodule

>>> hw/rtl/cam_front.sv
// Front end: accepts words, tracks the indirect sequence and classifies.
`timescale 1ns / 1ps

module cam_front import cam_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        operation,
   input  logic [3:0]  mode,
   input  logic [7:0]  operand_low,
   input  logic [7:0]  operand_high,
   input  logic [7:0]  index_x,
   input  logic [7:0]  index_y,
   input  logic [15:0] operand_pc,
   input  logic [7:0]  read_data,
   output logic        cmd_valid,
   output cmd_type     cmd
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  held_mode_ff, held_mode_in;
   logic [15:0] pointer_ff, pointer_in;
   logic [7:0]  low_byte_ff, low_byte_in;
   logic [7:0]  held_y_ff, held_y_in;

   logic [7:0]  ptr_next_lo;
   logic [15:0] second_ptr;
   logic [7:0]  zp_indexed;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         held_mode_ff <= 4'h0;
         pointer_ff   <= 16'h0000;
         low_byte_ff  <= 8'h00;
         held_y_ff    <= 8'h00;
      end else begin
         phase_ff     <= phase_in;
         held_mode_ff <= held_mode_in;
         pointer_ff   <= pointer_in;
         low_byte_ff  <= low_byte_in;
         held_y_ff    <= held_y_in;
      end
   end

   always_comb begin
      ptr_next_lo = pointer_ff[7:0] + 8'd1;
      // Plain indirect keeps the page-wrap quirk: the high byte never carries.
      if (held_mode_ff == MODE_IND) begin
         second_ptr = {pointer_ff[15:8], ptr_next_lo};
      end else begin
         second_ptr = {8'h00, ptr_next_lo};
      end
      zp_indexed = operand_low + index_x;
   end

   always_comb begin
      phase_in     = phase_ff;
      held_mode_in = held_mode_ff;
      pointer_in   = pointer_ff;
      low_byte_in  = low_byte_ff;
      held_y_in    = held_y_ff;
      cmd_valid    = 1'b0;
      cmd.kind     = CMD_DIRECT;
      cmd.mode     = mode;
      cmd.lo       = operand_low;
      cmd.hi       = operand_high;
      cmd.x        = index_x;
      cmd.y        = index_y;
      cmd.pc       = operand_pc;
      cmd.addr     = 16'h0000;
      if (accept) begin
         if (operation == OP_DATA) begin
            unique case (phase_ff)
               PH_FIRST: begin
                  low_byte_in = read_data;
                  phase_in    = PH_SECOND;
                  cmd_valid   = 1'b1;
                  cmd.kind    = CMD_READ;
                  cmd.addr    = second_ptr;
               end
               PH_SECOND: begin
                  phase_in  = PH_IDLE;
                  cmd_valid = 1'b1;
                  cmd.kind  = CMD_WORD;
                  cmd.addr  = {read_data, low_byte_ff};
                  cmd.y     = (held_mode_ff == MODE_INDY) ? held_y_ff : 8'h00;
               end
               default: begin
                  // drop a stray data word
                  phase_in = PH_IDLE;
               end
            endcase
         end else begin
            phase_in  = PH_IDLE;
            cmd_valid = 1'b1;
            if (mode == MODE_IND || mode == MODE_INDX || mode == MODE_INDY) begin
               held_mode_in = mode;
               held_y_in    = index_y;
               phase_in     = PH_FIRST;
               cmd.kind     = CMD_READ;
               if (mode == MODE_IND) begin
                  pointer_in = {operand_high, operand_low};
               end else if (mode == MODE_INDX) begin
                  pointer_in = {8'h00, zp_indexed};
               end else begin
                  pointer_in = {8'h00, operand_low};
               end
               cmd.addr = pointer_in;
            end
         end
      end
   end

endmodule

>>> hw/rtl/cam_queue.sv
// Short command queue between the front and the back.
`timescale 1ns / 1ps

module cam_queue import cam_pkg::*; #(
   parameter int DEPTH = QueueDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output logic    not_empty,
   output cmd_type rd_data
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type              store_ff [DEPTH];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic                 do_wr;
   logic                 do_rd;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = store_ff[rd_ptr_ff];
   assign do_wr     = wr_en && !full;
   assign do_rd     = rd_en && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CntW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> hw/rtl/cam_back.sv
// Back end: computes effective addresses and holds the result register.
`timescale 1ns / 1ps

module cam_back import cam_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_present,
   input  cmd_type     cmd,
   output logic        cmd_take,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_kind,
   output logic [15:0] rsp_address,
   output logic        rsp_use_accumulator,
   output logic        rsp_page_crossed
);

   logic        out_valid_ff, out_valid_in;
   logic        kind_ff, kind_in;
   logic [15:0] address_ff, address_in;
   logic        acc_ff, acc_in;
   logic        crossed_ff, crossed_in;

   logic [15:0] base;
   logic [15:0] next_pc;
   logic [15:0] target;
   logic [7:0]  zpx;
   logic [7:0]  zpy;

   // Refill the output register whenever it is empty or being drained.
   assign cmd_take  = cmd_present && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;

   always_comb begin
      base    = {cmd.hi, cmd.lo};
      next_pc = cmd.pc + 16'd1;
      target  = next_pc + {{8{cmd.lo[7]}}, cmd.lo};
      zpx     = cmd.lo + cmd.x;
      zpy     = cmd.lo + cmd.y;
      kind_in    = KIND_DONE;
      address_in = 16'h0000;
      acc_in     = 1'b0;
      crossed_in = 1'b0;
      unique case (cmd.kind)
         CMD_READ: begin
            kind_in    = KIND_READ;
            address_in = cmd.addr;
         end
         CMD_WORD: begin
            address_in = cmd.addr + {8'h00, cmd.y};
         end
         default: begin
            unique case (cmd.mode)
               MODE_ACC:  acc_in = 1'b1;
               MODE_ABS:  address_in = base;
               MODE_ABSX: address_in = base + {8'h00, cmd.x};
               MODE_ABSY: address_in = base + {8'h00, cmd.y};
               MODE_IMM:  address_in = cmd.pc;
               MODE_REL: begin
                  address_in = target;
                  crossed_in = (target[15:8] != next_pc[15:8]);
               end
               MODE_ZPG:  address_in = {8'h00, cmd.lo};
               MODE_ZPGX: address_in = {8'h00, zpx};
               MODE_ZPGY: address_in = {8'h00, zpy};
               default:   address_in = 16'h0000;
            endcase
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd_take) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         kind_ff    <= kind_in;
         address_ff <= address_in;
         acc_ff     <= acc_in;
         crossed_ff <= crossed_in;
      end
   end

   assign rsp_kind            = kind_ff;
   assign rsp_address         = address_ff;
   assign rsp_use_accumulator = acc_ff;
   assign rsp_page_crossed    = crossed_ff;

endmodule

>>> hw/rtl/cam_checker.sv
// Port-level checks for the addressing mode unit, bound to the top level.
`timescale 1ns / 1ps

module cam_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_kind,
   input logic [15:0] rsp_address,
   input logic        rsp_use_accumulator,
   input logic        rsp_page_crossed
);

   // Reset leaves nothing to deliver and room to accept.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result or full flag present after reset");

   // A stalled result holds.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_address) && $stable(rsp_kind))
      else $error("stalled result changed");

   // Read requests carry no flags.
   a_read_no_flags: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_kind |-> !rsp_use_accumulator && !rsp_page_crossed)
      else $error("read request with a flag set");

   // Accumulator operand means address zero.
   a_acc_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_use_accumulator |-> rsp_kind && rsp_address == 16'h0000
         && !rsp_page_crossed)
      else $error("accumulator result malformed");

endmodule

bind cpu_addressing_mode_unit cam_checker u_cam_checker (
   .clock               (clock),
   .reset               (reset),
   .req_full            (req_full),
   .rsp_empty           (rsp_empty),
   .rsp_pop             (rsp_pop),
   .rsp_kind            (rsp_kind),
   .rsp_address         (rsp_address),
   .rsp_use_accumulator (rsp_use_accumulator),
   .rsp_page_crossed    (rsp_page_crossed)
);

>>> dv/cpu_addressing_mode_unit_test.sv
// Testbench for the addressing mode unit: directed, back-pressure and random traffic.
`timescale 1ns / 1ps

module cpu_addressing_mode_unit_test;
   import cam_pkg::*;

   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_SETTLE    = 8;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic        kind;
      logic [15:0] address;
      logic        use_acc;
      logic        crossed;
   } addr_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_operation = 1'b0;
   logic [3:0]  req_mode = 4'd0;
   logic [7:0]  req_operand_low = 8'd0;
   logic [7:0]  req_operand_high = 8'd0;
   logic [7:0]  req_index_x = 8'd0;
   logic [7:0]  req_index_y = 8'd0;
   logic [15:0] req_operand_pc = 16'd0;
   logic [7:0]  req_read_data = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_kind;
   logic [15:0] rsp_address;
   logic        rsp_use_accumulator;
   logic        rsp_page_crossed;

   // Predictor state of the indirect sequencer
   phase_type   seq_phase = PH_IDLE;
   logic [3:0]  seq_mode = 4'd0;
   logic [15:0] seq_pointer = 16'd0;
   logic [7:0]  seq_low = 8'd0;
   logic [7:0]  seq_y = 8'd0;

   addr_result_type expected_addr_results[$];
   int          mismatch_count = 0;
   int          caused_count = 0;
   int          burst_left = 0;
   bit          gapless = 1'b0;
   bit          hold_off_request = 1'b0;
   int          idle_cycles = 0;
   int          rx_cycle = 0;
   int          rx_style = 0;
   logic [7:0]  rx_mask = 8'hFF;

   cpu_addressing_mode_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_operation       (req_operation),
      .req_mode            (req_mode),
      .req_operand_low     (req_operand_low),
      .req_operand_high    (req_operand_high),
      .req_index_x         (req_index_x),
      .req_index_y         (req_index_y),
      .req_operand_pc      (req_operand_pc),
      .req_read_data       (req_read_data),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_kind            (rsp_kind),
      .rsp_address         (rsp_address),
      .rsp_use_accumulator (rsp_use_accumulator),
      .rsp_page_crossed    (rsp_page_crossed)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] pick_pc();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {pick_byte(), 8'hFF};
         3: return {pick_byte(), 8'h80};
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [3:0] pick_mode();
      logic [3:0] m;
      if ($urandom_range(0, 9) < 4) begin
         case ($urandom_range(0, 2))
            0: m = MODE_IND;
            1: m = MODE_INDX;
            default: m = MODE_INDY;
         endcase
      end else begin
         m = 4'($urandom_range(0, 15));
      end
      return m;
   endfunction

   // Compute the effective address or next read request for one accepted word.
   function automatic bit predict_addressing(input logic op, input logic [3:0] mode,
                                             input logic [7:0] lo, input logic [7:0] hi,
                                             input logic [7:0] x, input logic [7:0] y,
                                             input logic [15:0] pc, input logic [7:0] data);
      addr_result_type r;
      logic [15:0]  next_pc;
      logic [15:0]  word;
      r = '{kind: KIND_DONE, address: 16'h0000, use_acc: 1'b0, crossed: 1'b0};
      if (op == OP_DATA) begin
         case (seq_phase)
            PH_FIRST: begin
               seq_low = data;
               seq_phase = PH_SECOND;
               r.kind = KIND_READ;
               // plain indirect wraps the low byte inside its page
               if (seq_mode == MODE_IND) begin
                  r.address = {seq_pointer[15:8], seq_pointer[7:0] + 8'd1};
               end else begin
                  r.address = {8'h00, seq_pointer[7:0] + 8'd1};
               end
            end
            PH_SECOND: begin
               word = {data, seq_low};
               if (seq_mode == MODE_INDY) begin
                  word = word + {8'h00, seq_y};
               end
               seq_phase = PH_IDLE;
               r.address = word;
            end
            default: begin
               seq_phase = PH_IDLE;
               return 1'b0;
            end
         endcase
      end else begin
         seq_phase = PH_IDLE;
         case (mode)
            MODE_ACC:  r.use_acc = 1'b1;
            MODE_ABS:  r.address = {hi, lo};
            MODE_ABSX: r.address = {hi, lo} + {8'h00, x};
            MODE_ABSY: r.address = {hi, lo} + {8'h00, y};
            MODE_IMM:  r.address = pc;
            MODE_IND, MODE_INDX, MODE_INDY: begin
               seq_mode = mode;
               seq_y = y;
               if (mode == MODE_IND) begin
                  seq_pointer = {hi, lo};
               end else if (mode == MODE_INDX) begin
                  seq_pointer = {8'h00, lo + x};
               end else begin
                  seq_pointer = {8'h00, lo};
               end
               seq_phase = PH_FIRST;
               r.kind = KIND_READ;
               r.address = seq_pointer;
            end
            MODE_REL: begin
               next_pc = pc + 16'd1;
               r.address = next_pc + {{8{lo[7]}}, lo};
               r.crossed = (r.address[15:8] != next_pc[15:8]);
            end
            MODE_ZPG:  r.address = {8'h00, lo};
            MODE_ZPGX: r.address = {8'h00, lo + x};
            MODE_ZPGY: r.address = {8'h00, lo + y};
            default:   r.address = 16'h0000;
         endcase
      end
      expected_addr_results.push_back(r);
      return 1'b1;
   endfunction

   // Offer one word, idling between bursts, and hold it until the block takes it.
   task automatic send_word(input logic op, input logic [3:0] mode, input logic [7:0] lo,
                            input logic [7:0] hi, input logic [7:0] x, input logic [7:0] y,
                            input logic [15:0] pc, input logic [7:0] data);
      int gap;
      if (burst_left == 0 && !gapless) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_push = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      @(negedge clock);
      req_operation    = op;
      req_mode         = mode;
      req_operand_low  = lo;
      req_operand_high = hi;
      req_index_x      = x;
      req_index_y      = y;
      req_operand_pc   = pc;
      req_read_data    = data;
      req_push         = 1'b1;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      if (predict_addressing(op, mode, lo, hi, x, y, pc, data)) begin
         caused_count++;
      end
      if (burst_left > 0) burst_left--;
   endtask

   task automatic send_begin(input logic [3:0] mode, input logic [7:0] lo, input logic [7:0] hi,
                             input logic [7:0] x, input logic [7:0] y, input logic [15:0] pc);
      send_word(OP_BEGIN, mode, lo, hi, x, y, pc, pick_byte());
   endtask

   task automatic send_data(input logic [7:0] data);
      send_word(OP_DATA, 4'($urandom()), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                pick_pc(), data);
   endtask

   // One instruction with random content; indirect ones mostly get both bytes back.
   task automatic send_sequence();
      logic [3:0] mode;
      int         bytes_back;
      if ($urandom_range(0, 99) < 6) begin
         send_data(pick_byte());
      end else begin
         mode = pick_mode();
         send_begin(mode, pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_pc());
         if (mode == MODE_IND || mode == MODE_INDX || mode == MODE_INDY) begin
            bytes_back = ($urandom_range(0, 99) < 85) ? 2 : $urandom_range(0, 1);
            repeat (bytes_back) send_data(pick_byte());
         end
      end
   endtask

   // Stop offering words and let every expected result come out.
   task automatic wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      burst_left = 0;
      while (expected_addr_results.size() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   task automatic test_direct_modes();
      send_begin(MODE_ACC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      send_begin(MODE_IMP, 8'h12, 8'h34, 8'h56, 8'h78, 16'h9ABC);
      send_begin(MODE_ABS, 8'hFF, 8'hFF, 8'h00, 8'h00, 16'h0000);
      send_begin(MODE_ABSX, 8'hFF, 8'hFF, 8'h01, 8'h00, 16'h1234);
      send_begin(MODE_ABSY, 8'hF0, 8'h12, 8'h00, 8'h20, 16'h1234);
      send_begin(MODE_IMM, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF);
      send_begin(MODE_ZPG, 8'hFF, 8'hAA, 8'h00, 8'h00, 16'h0000);
      send_begin(MODE_ZPGX, 8'hF0, 8'hAA, 8'h20, 8'h00, 16'h0000);
      send_begin(MODE_ZPGY, 8'hFF, 8'h55, 8'h00, 8'hFF, 16'h0000);
      send_begin(MODE_REL, 8'h7F, 8'h00, 8'h00, 8'h00, 16'h10FE);
      send_begin(MODE_REL, 8'h80, 8'h00, 8'h00, 8'h00, 16'h1000);
      send_begin(MODE_REL, 8'h10, 8'h00, 8'h00, 8'h00, 16'h2000);
      send_begin(MODE_REL, 8'h01, 8'h00, 8'h00, 8'h00, 16'hFFFF);
      send_begin(4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
   endtask

   task automatic test_indirect_sequences();
      // page-wrap quirk on the pointer's second byte
      send_begin(MODE_IND, 8'hFF, 8'h12, 8'h00, 8'h00, 16'h0000);
      send_data(8'h34);
      send_data(8'h56);
      send_begin(MODE_INDX, 8'hFF, 8'hFF, 8'h02, 8'h00, 16'h0000);
      send_data(8'hFF);
      send_data(8'h00);
      send_begin(MODE_INDY, 8'hFF, 8'h00, 8'h00, 8'hFF, 16'h0000);
      send_data(8'hFF);
      send_data(8'hFF);
      // stray byte while idle, then a begin that abandons a pending fetch
      send_data(8'hA5);
      send_begin(MODE_IND, 8'h00, 8'h80, 8'h00, 8'h00, 16'h0000);
      send_begin(MODE_ABS, 8'h00, 8'h80, 8'h00, 8'h00, 16'h0000);
   endtask

   task automatic test_backpressure();
      hold_off_request = 1'b1;
      gapless = 1'b1;
      repeat (12) send_sequence();
      gapless = 1'b0;
   endtask

   task automatic test_random_traffic(input int count);
      int start;
      start = caused_count;
      while (caused_count - start < count) send_sequence();
   endtask

   // Receiver: a long hold-off on request, otherwise a stall pattern that changes over time.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_pop = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         if (rx_cycle % 50 == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_mask = 8'($urandom()) | 8'h01;
         end
         case (rx_style)
            0: rsp_pop = 1'b1;
            1: rsp_pop = 1'($urandom_range(0, 1));
            2: rsp_pop = ($urandom_range(0, 3) == 0);
            default: rsp_pop = rx_mask[rx_cycle % 8];
         endcase
         rx_cycle++;
      end
   end

   // Compare each popped word with the oldest expectation.
   always @(posedge clock) begin
      addr_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_addr_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected result: kind %0d addr %h acc %0d cross %0d",
                        rsp_kind, rsp_address, rsp_use_accumulator, rsp_page_crossed);
            end
         end else begin
            want = expected_addr_results.pop_front();
            if (rsp_kind !== want.kind || rsp_address !== want.address ||
                rsp_use_accumulator !== want.use_acc || rsp_page_crossed !== want.crossed) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display({"mismatch: want kind %0d addr %h acc %0d cross %0d,",
                            " got kind %0d addr %h acc %0d cross %0d"},
                           want.kind, want.address, want.use_acc, want.crossed,
                           rsp_kind, rsp_address, rsp_use_accumulator, rsp_page_crossed);
               end
            end
         end
      end
   end

   // End the run if neither side moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_direct_modes();
      wait_drained();
      test_indirect_sequences();
      wait_drained();
      test_backpressure();
      wait_drained();
      test_random_traffic(600);
      wait_drained();
      test_random_traffic(600);
      wait_drained();
      if (mismatch_count == 0 && expected_addr_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
